[src/dewq_pkg.sv]
package dewq_pkg;

    localparam int POS_W   = 8;
    localparam int STAMP_W = 32;
    localparam int CNT_W   = 7;

    localparam logic OP_MARK  = 1'b0;
    localparam logic OP_FLUSH = 1'b1;

    typedef struct packed {
        logic [POS_W-1:0]   position;
        logic [STAMP_W-1:0] stamp;
    } t_entry;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SCAN,
        S_MARK_WR,
        S_EMIT,
        S_SHIFT
    } t_state;

    typedef enum logic [1:0] {
        RES_ENTRY,
        RES_REFUSE,
        RES_EMPTY
    } t_res_kind;

endpackage

[src/dirty_entry_writeback_queue_unit.sv]
// Oldest-first dirty write-back queue. Holds up to TABLE_ENTRIES (position, stamp) entries in
// insertion order in one simple dual-port memory (one write, one registered read port). A mark
// request scans every held entry for its position: a hit rewrites that entry's stamp, a miss
// appends at the tail, and a full table returns one result with refused set. A flush request
// removes min(flush_count, fill) entries (all of them with flush_all), each time the smallest
// stamp, earliest inserted on ties; the tail is then shifted down one slot. A flush on an empty
// table returns one result with valid_res low; a zero count on a non-empty table returns
// nothing. With C entries held, a mark scans the C entries (the scan reads one entry per
// cycle from the memory's single read port) and then writes the entry or refuses it. A flush,
// per removed entry, scans for the smallest stamp, loads the output register once the receiver
// is not stalling it, and then shifts the tail above the removed slot down by one slot.
// One request is worked at a time; o_stall is high until its memory traffic is done, while
// its last result may still sit in the output register. The memory needs no init: only slots
// below the fill are read.
module dirty_entry_writeback_queue_unit #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    // request side
    input  logic                         i_valid,
    output logic                         o_stall,
    input  logic                         i_op,
    input  logic [dewq_pkg::POS_W-1:0]   i_position,
    input  logic [dewq_pkg::STAMP_W-1:0] i_stamp,
    input  logic [dewq_pkg::CNT_W-1:0]   i_flush_count,
    input  logic                         i_flush_all,
    // result side
    output logic                         o_valid,
    input  logic                         i_stall,
    output logic [dewq_pkg::POS_W-1:0]   o_out_position,
    output logic [dewq_pkg::STAMP_W-1:0] o_out_stamp,
    output logic                         o_valid_res,
    output logic                         o_last,
    output logic                         o_refused
);

    localparam int IW = $clog2(TABLE_ENTRIES);      // slot index
    localparam int CW = $clog2(TABLE_ENTRIES + 1);  // fill count, 0..TABLE_ENTRIES

    // control
    dewq_pkg::t_state    r_state, n_state;
    logic [CW-1:0]       r_count, n_count;
    logic [CW-1:0]       r_left, n_left;        // removals still owed by this flush
    logic [CW-1:0]       r_issue, n_issue;      // next read address
    logic                r_rv, n_rv;            // read data returns this cycle
    logic                r_ovalid, n_ovalid;

    // request and scan datapath
    logic                        r_is_flush, n_is_flush;
    logic [dewq_pkg::POS_W-1:0]  r_pos, n_pos;
    logic [dewq_pkg::STAMP_W-1:0] r_stamp, n_stamp;
    logic [IW-1:0]               r_ridx, n_ridx;       // slot of returning data
    logic                        r_hit, n_hit;
    logic [IW-1:0]               r_hit_idx, n_hit_idx;
    dewq_pkg::t_entry            r_best, n_best;
    logic [IW-1:0]               r_best_idx, n_best_idx;
    dewq_pkg::t_res_kind         r_kind, n_kind;

    // output register
    logic [dewq_pkg::POS_W-1:0]   r_opos, n_opos;
    logic [dewq_pkg::STAMP_W-1:0] r_ostamp, n_ostamp;
    logic                         r_ovres, n_ovres;
    logic                         r_olast, n_olast;
    logic                         r_oref, n_oref;

    // memory ports
    logic                mem_we, mem_re;
    logic [IW-1:0]       mem_waddr, mem_raddr;
    dewq_pkg::t_entry    mem_wdata, mem_rdata;

    logic                in_acc, out_free, issue_go, scan_last, shift_done;
    logic                match, better;
    logic [CW-1:0]       n_take;

    dewq_mem #(
        .DEPTH (TABLE_ENTRIES)
    ) u_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_re    (mem_re),
        .i_raddr (mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign o_stall   = (r_state != dewq_pkg::S_IDLE);
    assign in_acc    = i_valid && !o_stall;
    assign out_free  = !r_ovalid || !i_stall;
    assign issue_go  = (r_issue < r_count);
    // last entry of a scan comes back from memory this cycle
    assign scan_last = r_rv && (CW'(r_ridx) == (r_count - CW'(1)));
    assign shift_done = !issue_go && !r_rv;

    assign match  = r_rv && (mem_rdata.position == r_pos);
    // strict less-than keeps the earliest slot on equal stamps
    assign better = r_rv && ((r_ridx == '0) || (mem_rdata.stamp < r_best.stamp));

    // removals for a flush, saturated at the fill
    always_comb begin
        if (i_flush_all) begin
            n_take = r_count;
        end else if (i_flush_count < dewq_pkg::CNT_W'(r_count)) begin
            n_take = CW'(i_flush_count);
        end else begin
            n_take = r_count;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dewq_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_op == dewq_pkg::OP_MARK) begin
                        n_state = (r_count == '0) ? dewq_pkg::S_MARK_WR : dewq_pkg::S_SCAN;
                    end else if (r_count == '0) begin
                        n_state = dewq_pkg::S_EMIT;
                    end else if (n_take != '0) begin
                        n_state = dewq_pkg::S_SCAN;
                    end
                end
            end
            dewq_pkg::S_SCAN: begin
                if (scan_last) begin
                    n_state = r_is_flush ? dewq_pkg::S_EMIT : dewq_pkg::S_MARK_WR;
                end
            end
            dewq_pkg::S_MARK_WR: begin
                if (r_hit || (r_count < CW'(TABLE_ENTRIES))) begin
                    n_state = dewq_pkg::S_IDLE;
                end else begin
                    n_state = dewq_pkg::S_EMIT;
                end
            end
            dewq_pkg::S_EMIT: begin
                if (out_free) begin
                    n_state = (r_kind == dewq_pkg::RES_ENTRY) ? dewq_pkg::S_SHIFT
                                                              : dewq_pkg::S_IDLE;
                end
            end
            dewq_pkg::S_SHIFT: begin
                if (shift_done) begin
                    n_state = (r_left == CW'(1)) ? dewq_pkg::S_IDLE : dewq_pkg::S_SCAN;
                end
            end
            default: n_state = dewq_pkg::S_IDLE;
        endcase
    end

    // datapath, memory control and output register
    always_comb begin
        n_count    = r_count;
        n_left     = r_left;
        n_issue    = r_issue;
        n_rv       = 1'b0;
        n_is_flush = r_is_flush;
        n_pos      = r_pos;
        n_stamp    = r_stamp;
        n_ridx     = r_ridx;
        n_hit      = r_hit;
        n_hit_idx  = r_hit_idx;
        n_best     = r_best;
        n_best_idx = r_best_idx;
        n_kind     = r_kind;
        n_ovalid   = r_ovalid && i_stall;
        n_opos     = r_opos;
        n_ostamp   = r_ostamp;
        n_ovres    = r_ovres;
        n_olast    = r_olast;
        n_oref     = r_oref;
        mem_we     = 1'b0;
        mem_waddr  = '0;
        mem_wdata  = '0;
        mem_re     = 1'b0;
        mem_raddr  = r_issue[IW-1:0];

        unique case (r_state)
            dewq_pkg::S_IDLE: begin
                if (in_acc) begin
                    n_is_flush = (i_op == dewq_pkg::OP_FLUSH);
                    n_pos      = i_position;
                    n_stamp    = i_stamp;
                    n_left     = n_take;
                    n_issue    = '0;
                    n_hit      = 1'b0;
                    n_kind     = ((i_op == dewq_pkg::OP_FLUSH) && (r_count == '0))
                               ? dewq_pkg::RES_EMPTY : dewq_pkg::RES_ENTRY;
                end
            end
            dewq_pkg::S_SCAN: begin
                mem_re = issue_go;
                n_rv   = issue_go;
                n_ridx = r_issue[IW-1:0];
                if (issue_go) begin
                    n_issue = r_issue + CW'(1);
                end
                if (!r_is_flush && match && !r_hit) begin
                    n_hit     = 1'b1;
                    n_hit_idx = r_ridx;
                end
                if (r_is_flush && better) begin
                    n_best     = mem_rdata;
                    n_best_idx = r_ridx;
                end
            end
            dewq_pkg::S_MARK_WR: begin
                mem_wdata.position = r_pos;
                mem_wdata.stamp    = r_stamp;
                if (r_hit) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_hit_idx;
                end else if (r_count < CW'(TABLE_ENTRIES)) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_count[IW-1:0];
                    n_count   = r_count + CW'(1);
                end else begin
                    n_kind = dewq_pkg::RES_REFUSE;
                end
            end
            dewq_pkg::S_EMIT: begin
                if (out_free) begin
                    n_ovalid = 1'b1;
                    unique case (r_kind)
                        dewq_pkg::RES_ENTRY: begin
                            n_opos   = r_best.position;
                            n_ostamp = r_best.stamp;
                            n_ovres  = 1'b1;
                            n_olast  = (r_left == CW'(1));
                            n_oref   = 1'b0;
                        end
                        dewq_pkg::RES_REFUSE: begin
                            n_opos   = r_pos;
                            n_ostamp = r_stamp;
                            n_ovres  = 1'b0;
                            n_olast  = 1'b1;
                            n_oref   = 1'b1;
                        end
                        dewq_pkg::RES_EMPTY: begin
                            n_opos   = '0;
                            n_ostamp = '0;
                            n_ovres  = 1'b0;
                            n_olast  = 1'b1;
                            n_oref   = 1'b0;
                        end
                        default: begin
                            n_opos   = '0;
                            n_ostamp = '0;
                            n_ovres  = 1'b0;
                            n_olast  = 1'b1;
                            n_oref   = 1'b0;
                        end
                    endcase
                    // tail shift starts at the slot after the removed one
                    n_issue = CW'(r_best_idx) + CW'(1);
                end
            end
            dewq_pkg::S_SHIFT: begin
                // read slot i+1, write it to slot i in the next cycle
                mem_re = issue_go;
                n_rv   = issue_go;
                n_ridx = r_issue[IW-1:0];
                if (issue_go) begin
                    n_issue = r_issue + CW'(1);
                end
                if (r_rv) begin
                    mem_we    = 1'b1;
                    mem_waddr = r_ridx - IW'(1);
                    mem_wdata = mem_rdata;
                end
                if (shift_done) begin
                    n_count = r_count - CW'(1);
                    n_left  = r_left - CW'(1);
                    n_issue = '0;
                end
            end
            default: begin
                n_rv = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= dewq_pkg::S_IDLE;
            r_count  <= '0;
            r_left   <= '0;
            r_issue  <= '0;
            r_rv     <= 1'b0;
            r_ovalid <= 1'b0;
            r_hit    <= 1'b0;
            r_kind   <= dewq_pkg::RES_ENTRY;
        end else begin
            r_state  <= n_state;
            r_count  <= n_count;
            r_left   <= n_left;
            r_issue  <= n_issue;
            r_rv     <= n_rv;
            r_ovalid <= n_ovalid;
            r_hit    <= n_hit;
            r_kind   <= n_kind;
        end
    end

    always_ff @(posedge i_clk) begin
        r_is_flush <= n_is_flush;
        r_pos      <= n_pos;
        r_stamp    <= n_stamp;
        r_ridx     <= n_ridx;
        r_hit_idx  <= n_hit_idx;
        r_best     <= n_best;
        r_best_idx <= n_best_idx;
        r_opos     <= n_opos;
        r_ostamp   <= n_ostamp;
        r_ovres    <= n_ovres;
        r_olast    <= n_olast;
        r_oref     <= n_oref;
    end

    assign o_valid        = r_ovalid;
    assign o_out_position = r_opos;
    assign o_out_stamp    = r_ostamp;
    assign o_valid_res    = r_ovres;
    assign o_last         = r_olast;
    assign o_refused      = r_oref;

    // fill never exceeds the table
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CW'(TABLE_ENTRIES))
        else $error("fill count above table size");

    // a scan is only started on a non-empty table
    a_scan_nonempty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == dewq_pkg::S_SCAN) |-> (r_count != '0))
        else $error("scan on empty table");

    // a refusal is a single, final, non-entry result
    a_refuse_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_refused) |-> (o_last && !o_valid_res))
        else $error("malformed refusal result");

    // tail shift writes only below the last held slot
    a_shift_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((r_state == dewq_pkg::S_SHIFT) && mem_we) |-> (CW'(mem_waddr) < (r_count - CW'(1))))
        else $error("shift write beyond fill");

endmodule

[src/dewq_mem.sv]
module dewq_mem #(
    parameter int DEPTH = 64
) (
    input  logic                      i_clk,
    input  logic                      i_we,
    input  logic [$clog2(DEPTH)-1:0]  i_waddr,
    input  dewq_pkg::t_entry          i_wdata,
    input  logic                      i_re,
    input  logic [$clog2(DEPTH)-1:0]  i_raddr,
    output dewq_pkg::t_entry          o_rdata
);

    dewq_pkg::t_entry r_mem [DEPTH];
    dewq_pkg::t_entry r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

[tb/sv/writeback_order_checker.sv]
module writeback_order_checker #(
    parameter int TABLE_ENTRIES = 64
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_req_valid,
    input  logic                         i_req_stall,
    input  logic                         i_op,
    input  logic [dewq_pkg::POS_W-1:0]   i_position,
    input  logic [dewq_pkg::STAMP_W-1:0] i_stamp,
    input  logic [dewq_pkg::CNT_W-1:0]   i_flush_count,
    input  logic                         i_flush_all,
    input  logic                         i_res_valid,
    input  logic                         i_res_stall,
    input  logic [dewq_pkg::POS_W-1:0]   i_out_position,
    input  logic [dewq_pkg::STAMP_W-1:0] i_out_stamp,
    input  logic                         i_valid_res,
    input  logic                         i_last,
    input  logic                         i_refused,
    output int                           o_mismatches,
    output int                           o_pending,
    output int                           o_results,
    output int                           o_refusals,
    output int                           o_empty_flushes
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [dewq_pkg::POS_W-1:0]   position;
        logic [dewq_pkg::STAMP_W-1:0] stamp;
        logic                         valid_res;
        logic                         last;
        logic                         refused;
    } t_writeback;

    t_writeback                   pending_writebacks[$];
    t_writeback                   oldest_due;
    logic [dewq_pkg::POS_W-1:0]   held_pos[TABLE_ENTRIES];
    logic [dewq_pkg::STAMP_W-1:0] held_stamp[TABLE_ENTRIES];
    int                           held_fill;

    // mirror of the dirty table; queues the write-backs one request causes
    task automatic predict_writebacks(input logic op, input logic [dewq_pkg::POS_W-1:0] pos,
                                      input logic [dewq_pkg::STAMP_W-1:0] stamp,
                                      input logic [dewq_pkg::CNT_W-1:0] cnt,
                                      input logic all);
        int         hit;
        int         oldest;
        int         n;
        t_writeback due;
        hit = -1;
        if (op == dewq_pkg::OP_MARK) begin
            for (int i = 0; i < held_fill; i++) begin
                if (hit < 0 && held_pos[i] == pos) hit = i;
            end
            if (hit >= 0) begin
                held_stamp[hit] = stamp;
            end else if (held_fill >= TABLE_ENTRIES) begin
                due = '{position: pos, stamp: stamp, valid_res: 1'b0,
                        last: 1'b1, refused: 1'b1};
                pending_writebacks = {pending_writebacks, due};
                o_refusals++;
            end else begin
                held_pos[held_fill]   = pos;
                held_stamp[held_fill] = stamp;
                held_fill++;
            end
        end else if (held_fill == 0) begin
            due = '{position: '0, stamp: '0, valid_res: 1'b0, last: 1'b1, refused: 1'b0};
            pending_writebacks = {pending_writebacks, due};
            o_empty_flushes++;
        end else begin
            n = all ? held_fill : ((int'(cnt) < held_fill) ? int'(cnt) : held_fill);
            for (int k = 0; k < n; k++) begin
                // strict compare keeps the earliest inserted entry on equal stamps
                oldest = 0;
                for (int i = 1; i < held_fill; i++) begin
                    if (held_stamp[i] < held_stamp[oldest]) oldest = i;
                end
                due = '{position: held_pos[oldest], stamp: held_stamp[oldest],
                        valid_res: 1'b1, last: (k == n - 1), refused: 1'b0};
                pending_writebacks = {pending_writebacks, due};
                for (int i = oldest; i < held_fill - 1; i++) begin
                    held_pos[i]   = held_pos[i + 1];
                    held_stamp[i] = held_stamp[i + 1];
                end
                held_fill--;
            end
        end
    endtask

    task automatic check_field(input string field, input logic [dewq_pkg::STAMP_W-1:0] want,
                               input logic [dewq_pkg::STAMP_W-1:0] got);
        if (got !== want) begin
            o_mismatches++;
            $display("%0t: %s expected %0d, got %0d", $time, field, want, got);
        end
    endtask

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            held_fill = 0;
            pending_writebacks.delete();
        end else begin
            if (i_res_valid && !i_res_stall) begin
                o_results++;
                if (pending_writebacks.size() == 0) begin
                    o_mismatches++;
                    $display("%0t: unexpected result, expected nothing, got pos %0d stamp %0d",
                             $time, i_out_position, i_out_stamp);
                end else begin
                    oldest_due = pending_writebacks.pop_front();
                    check_field("out_position", dewq_pkg::STAMP_W'(oldest_due.position),
                                dewq_pkg::STAMP_W'(i_out_position));
                    check_field("out_stamp", oldest_due.stamp, i_out_stamp);
                    check_field("valid_res", dewq_pkg::STAMP_W'(oldest_due.valid_res),
                                dewq_pkg::STAMP_W'(i_valid_res));
                    check_field("last", dewq_pkg::STAMP_W'(oldest_due.last),
                                dewq_pkg::STAMP_W'(i_last));
                    check_field("refused", dewq_pkg::STAMP_W'(oldest_due.refused),
                                dewq_pkg::STAMP_W'(i_refused));
                end
            end
            if (i_req_valid && !i_req_stall)
                predict_writebacks(i_op, i_position, i_stamp, i_flush_count, i_flush_all);
        end
        o_pending = pending_writebacks.size();
    end

endmodule

[tb/sv/dirty_entry_writeback_queue_unit_tb.sv]
module dirty_entry_writeback_queue_unit_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int TABLE_ENTRIES = 64;
    localparam int HOLD_CYCLES   = 600;   // receiver hold-off, long enough to back up requests
    localparam int DRAIN_CYCLES  = 400;   // longer than one full-table removal
    localparam int TOTAL_ITEMS   = 410;   // request count after which no new round starts, directed ones included

    // kinds of random rounds
    typedef enum int {
        ROUND_BURST,   // marks from a narrow pool: many timestamp refreshes
        ROUND_FILL,    // distinct positions past capacity: refused marks
        ROUND_FLUSH,   // flush with a drawn count
        ROUND_DRAIN,   // flush_all
        ROUND_NOISE    // one request with every field drawn at random
    } t_round;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_valid;
    logic                         o_stall;
    logic                         i_op;
    logic [dewq_pkg::POS_W-1:0]   i_position;
    logic [dewq_pkg::STAMP_W-1:0] i_stamp;
    logic [dewq_pkg::CNT_W-1:0]   i_flush_count;
    logic                         i_flush_all;
    logic                         o_valid;
    logic                         i_stall;
    logic [dewq_pkg::POS_W-1:0]   o_out_position;
    logic [dewq_pkg::STAMP_W-1:0] o_out_stamp;
    logic                         o_valid_res;
    logic                         o_last;
    logic                         o_refused;

    int mismatches;
    int pending;
    int results;
    int refusals;
    int empty_flushes;

    int           n_sent    = 0;
    int           hold_asks = 0;      // long hold-offs asked for by the stimulus
    int           hold_runs = 0;      // long hold-offs done by the receiver
    bit           calm      = 1'b0;   // no idling on either side while set
    logic [31:0]  now_ms;

    dirty_entry_writeback_queue_unit #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .o_stall       (o_stall),
        .i_op          (i_op),
        .i_position    (i_position),
        .i_stamp       (i_stamp),
        .i_flush_count (i_flush_count),
        .i_flush_all   (i_flush_all),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_out_position(o_out_position),
        .o_out_stamp   (o_out_stamp),
        .o_valid_res   (o_valid_res),
        .o_last        (o_last),
        .o_refused     (o_refused)
    );

    writeback_order_checker #(
        .TABLE_ENTRIES(TABLE_ENTRIES)
    ) scoreboard (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_req_valid    (i_valid),
        .i_req_stall    (o_stall),
        .i_op           (i_op),
        .i_position     (i_position),
        .i_stamp        (i_stamp),
        .i_flush_count  (i_flush_count),
        .i_flush_all    (i_flush_all),
        .i_res_valid    (o_valid),
        .i_res_stall    (i_stall),
        .i_out_position (o_out_position),
        .i_out_stamp    (o_out_stamp),
        .i_valid_res    (o_valid_res),
        .i_last         (o_last),
        .i_refused      (o_refused),
        .o_mismatches   (mismatches),
        .o_pending      (pending),
        .o_results      (results),
        .o_refusals     (refusals),
        .o_empty_flushes(empty_flushes)
    );

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // Timeout, set well beyond the slowest legal run (every mark scans the table, every
    // removal scans and shifts it, plus stalls).
    initial begin
        #4_000_000;
        $display("timeout: %0d requests sent, %0d results still expected", n_sent, pending);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drive one request at the falling edge, after a random idle gap, and hold it
    // steady until the block takes it. Returns in the time step of acceptance.
    task automatic send_request(input logic op, input logic [dewq_pkg::POS_W-1:0] pos,
                                input logic [dewq_pkg::STAMP_W-1:0] stamp,
                                input logic [dewq_pkg::CNT_W-1:0] cnt, input logic all);
        @(negedge i_clk);
        while (!calm && $urandom_range(0, 99) < 25) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid       <= 1'b1;
        i_op          <= op;
        i_position    <= pos;
        i_stamp       <= stamp;
        i_flush_count <= cnt;
        i_flush_all   <= all;
        do @(posedge i_clk); while (o_stall);
        n_sent++;
    endtask

    // Unused fields of a request still carry random values so their bits toggle.
    task automatic mark(input logic [dewq_pkg::POS_W-1:0] pos,
                        input logic [dewq_pkg::STAMP_W-1:0] stamp);
        send_request(dewq_pkg::OP_MARK, pos, stamp,
                     dewq_pkg::CNT_W'($urandom_range(0, 64)), 1'($urandom_range(0, 1)));
    endtask

    task automatic flush(input logic [dewq_pkg::CNT_W-1:0] cnt, input logic all);
        send_request(dewq_pkg::OP_FLUSH, dewq_pkg::POS_W'($urandom), $urandom, cnt, all);
    endtask

    // Millisecond clock: small steps (zero step makes equal stamps), sometimes a jump.
    function automatic logic [dewq_pkg::STAMP_W-1:0] tick();
        if ($urandom_range(0, 7) == 0)
            now_ms = $urandom;
        else
            now_ms += $urandom_range(0, 3);
        return now_ms;
    endfunction

    // Mostly small counts; zero and the full 64 show up often.
    function automatic logic [dewq_pkg::CNT_W-1:0] pick_count();
        unique case ($urandom_range(0, 9))
            0:       return '0;
            1:       return dewq_pkg::CNT_W'(64);
            2:       return dewq_pkg::CNT_W'($urandom_range(0, 64));
            default: return dewq_pkg::CNT_W'($urandom_range(1, 8));
        endcase
    endfunction

    // Result side: random stall, plus a long hold-off when the stimulus asks for one.
    initial begin
        i_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_asks > hold_runs) begin
                i_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_runs++;
            end
            i_stall <= !calm && ($urandom_range(0, 99) < 25);
        end
    end

    initial begin
        t_round                     mode;
        int                         pick;
        int                         len;
        int                         round;
        logic [dewq_pkg::POS_W-1:0] base;

        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_op          = dewq_pkg::OP_MARK;
        i_position    = '0;
        i_stamp       = '0;
        i_flush_count = '0;
        i_flush_all   = 1'b0;
        now_ms        = $urandom;

        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----
        // flush on an empty table, with a count and with flush_all
        flush(dewq_pkg::CNT_W'(5), 1'b0);
        flush('0, 1'b1);
        // extremes of position and stamp, a tie, then a refresh of position 0
        mark(8'h00, 32'hFFFF_FFFF);
        mark(8'hFF, 32'h0000_0000);
        mark(8'hAA, 32'd100);
        mark(8'h55, 32'd100);
        mark(8'h00, 32'd50);
        // zero count on a non-empty table: nothing comes back
        flush('0, 1'b0);
        flush(dewq_pkg::CNT_W'(1), 1'b0);
        // count above the fill saturates; tie at 100 goes to 0xAA first
        flush(dewq_pkg::CNT_W'(64), 1'b0);
        mark(8'h80, 32'h8000_0000);
        mark(8'h7F, 32'h7FFF_FFFF);
        mark(8'h01, 32'h7FFF_FFFF);
        // flush_all ignores a zero count
        flush('0, 1'b1);
        // refresh lowers a stamp into a tie with a later entry
        mark(8'h3C, 32'd5);
        mark(8'hC3, 32'd3);
        mark(8'h3C, 32'd3);
        flush(dewq_pkg::CNT_W'(2), 1'b0);
        // table is empty again: flush_all with the top count bit set
        flush(dewq_pkg::CNT_W'(64), 1'b1);

        // ---- random rounds ----
        round = 0;
        while (n_sent < TOTAL_ITEMS) begin
            // a stretch in the middle runs without idling on either side
            calm = (n_sent >= TOTAL_ITEMS / 2) && (n_sent < TOTAL_ITEMS / 2 + 90);
            pick = $urandom_range(0, 9);
            if (round == 0)  mode = ROUND_FILL;
            else if (pick < 4)  mode = ROUND_BURST;
            else if (pick == 4) mode = ROUND_FILL;
            else if (pick < 8)  mode = ROUND_FLUSH;
            else if (pick == 8) mode = ROUND_DRAIN;
            else                mode = ROUND_NOISE;

            unique case (mode)
                ROUND_BURST: begin
                    base = dewq_pkg::POS_W'($urandom);
                    len  = $urandom_range(3, 20);
                    repeat (len) mark(base + dewq_pkg::POS_W'($urandom_range(0, 40)), tick());
                end
                ROUND_FILL: begin
                    base = dewq_pkg::POS_W'($urandom);
                    len  = TABLE_ENTRIES + $urandom_range(0, 8);
                    for (int i = 0; i < len; i++) mark(base + dewq_pkg::POS_W'(i), tick());
                    // fills in rounds that are a multiple of four: receiver holds off while a full drain backs up
                    if (round % 4 == 0) hold_asks++;
                    flush(pick_count(), 1'b1);
                end
                ROUND_FLUSH: flush(pick_count(), 1'b0);
                ROUND_DRAIN: flush(pick_count(), 1'b1);
                default: begin
                    if ($urandom_range(0, 1))
                        flush(dewq_pkg::CNT_W'($urandom_range(0, 64)),
                              1'($urandom_range(0, 1)));
                    else
                        mark(dewq_pkg::POS_W'($urandom), $urandom);
                end
            endcase
            round++;
        end
        calm = 1'b0;

        @(negedge i_clk);
        i_valid <= 1'b0;

        // wait for every expected write-back, then let a stray one show up
        while (pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        $display("%0d requests over %0d random rounds; %0d results checked in order",
                 n_sent, round, results);
        $display("%0d refused marks, %0d empty flushes, %0d long receiver hold-offs",
                 refusals, empty_flushes, hold_runs);
        if (mismatches == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("%0d mismatches", mismatches);
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule

[filelist.f]
src/dewq_pkg.sv
src/dewq_mem.sv
src/dirty_entry_writeback_queue_unit.sv
tb/sv/writeback_order_checker.sv
tb/sv/dirty_entry_writeback_queue_unit_tb.sv
